// ----- rtl/core/msva_pkg.sv -----
package msva_pkg;

  localparam int COORD_BITS = 16;
  localparam int IN_W       = 16;
  localparam int EXT_W      = (COORD_BITS > IN_W) ? COORD_BITS : IN_W;
  localparam int MIN_W      = 2 * COORD_BITS + 1;
  localparam int PROD_W     = 3 * COORD_BITS + 1;
  localparam int DET_W      = 3 * COORD_BITS + 3;
  localparam int ACC_W      = 64;
  localparam int VOL_W      = 62;

  // floor(n / 6) = (n * ceil(2^66 / 6)) >> 66 for any 64-bit magnitude n
  localparam int HALF_W      = ACC_W / 2;
  localparam int WIDE_W      = 2 * ACC_W;
  localparam int RECIP_SHIFT = ACC_W + 2;
  localparam logic [ACC_W-1:0] RECIP6 = 64'hAAAA_AAAA_AAAA_AAAB;
  localparam int DIV_STEPS   = 4;

  localparam int CALC_STEPS = 10;
  localparam int CNT_MAX    = (CALC_STEPS > DIV_STEPS) ? CALC_STEPS : DIV_STEPS;
  localparam int CNT_W      = $clog2(CNT_MAX);
  localparam logic [CNT_W-1:0] CALC_LAST = CNT_W'(CALC_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);

  typedef logic signed [IN_W-1:0]       in_coord_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [MIN_W-1:0]      minor_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DET_W-1:0]      det_t;
  typedef logic signed [ACC_W-1:0]      six_t;
  typedef logic signed [VOL_W-1:0]      vol_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    MS_Y2Z3,
    MS_Y3Z2,
    MS_Y3Z1,
    MS_Y1Z3,
    MS_Y1Z2,
    MS_Y2Z1,
    MS_X1M,
    MS_X2M,
    MS_X3M
  } mul_sel_e;

  typedef enum logic [1:0] {
    DET_HOLD,
    DET_LOAD,
    DET_ADD
  } det_op_e;

  // partial product of magnitude half times reciprocal half
  typedef enum logic [1:0] {
    PP_LL,
    PP_LH,
    PP_HL,
    PP_HH
  } pp_sel_e;

  typedef struct packed {
    logic     capture;
    mul_sel_e mul_sel;
    logic     hold_en;
    logic     minor_en;
    det_op_e  det_op;
    logic     acc_en;
    logic     div_step;
    pp_sel_e  pp_sel;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } dp_sts_t;

  // keep the low COORD_BITS bits of a coordinate and sign extend them
  function automatic coord_t sext_coord(in_coord_t v);
    logic [EXT_W-1:0] w;
    w = EXT_W'(unsigned'(v));
    return coord_t'(w[COORD_BITS-1:0]);
  endfunction

endpackage

// ----- rtl/core/msva_ctrl.sv -----
module msva_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  msva_pkg::dp_sts_t sts_i,
  output msva_pkg::ctl_cmd_t cmd_o
);
  import msva_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (cnt_q == CALC_LAST) begin
          state_d = ST_ACC;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ACC: begin
        cnt_d   = '0;
        state_d = sts_i.last ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = ST_OUT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // multiplier schedule: two y*z products form a minor, then x*minor joins the sum
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = MS_Y2Z3;
    cmd_o.det_op   = DET_HOLD;
    cmd_o.pp_sel   = PP_LL;
    in_stall_o     = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_CALC: begin
        unique case (cnt_q)
          CNT_W'(0): cmd_o.mul_sel = MS_Y2Z3;
          CNT_W'(1): begin
            cmd_o.mul_sel = MS_Y3Z2;
            cmd_o.hold_en = 1'b1;
          end
          CNT_W'(2): begin
            cmd_o.mul_sel  = MS_Y3Z1;
            cmd_o.minor_en = 1'b1;
          end
          CNT_W'(3): begin
            cmd_o.mul_sel = MS_Y1Z3;
            cmd_o.hold_en = 1'b1;
          end
          CNT_W'(4): begin
            cmd_o.mul_sel  = MS_X1M;
            cmd_o.minor_en = 1'b1;
          end
          CNT_W'(5): begin
            cmd_o.mul_sel = MS_Y1Z2;
            cmd_o.det_op  = DET_LOAD;
          end
          CNT_W'(6): begin
            cmd_o.mul_sel = MS_Y2Z1;
            cmd_o.hold_en = 1'b1;
          end
          CNT_W'(7): begin
            cmd_o.mul_sel  = MS_X2M;
            cmd_o.minor_en = 1'b1;
          end
          CNT_W'(8): begin
            cmd_o.mul_sel = MS_X3M;
            cmd_o.det_op  = DET_ADD;
          end
          CNT_W'(9): cmd_o.det_op = DET_ADD;
          default: cmd_o.det_op = DET_HOLD;
        endcase
      end
      ST_ACC:  cmd_o.acc_en   = 1'b1;
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        unique case (cnt_q)
          CNT_W'(0): cmd_o.pp_sel = PP_LL;
          CNT_W'(1): cmd_o.pp_sel = PP_LH;
          CNT_W'(2): cmd_o.pp_sel = PP_HL;
          default:   cmd_o.pp_sel = PP_HH;
        endcase
      end
      ST_OUT:  cmd_o.out_load = sts_i.out_free;
      default: cmd_o.det_op   = DET_HOLD;
    endcase
  end

endmodule

// ----- rtl/core/msva_datapath.sv -----
module msva_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msva_pkg::ctl_cmd_t cmd_i,
  output msva_pkg::dp_sts_t  sts_o,
  input  msva_pkg::in_coord_t first_x_i,
  input  msva_pkg::in_coord_t first_y_i,
  input  msva_pkg::in_coord_t first_z_i,
  input  msva_pkg::in_coord_t second_x_i,
  input  msva_pkg::in_coord_t second_y_i,
  input  msva_pkg::in_coord_t second_z_i,
  input  msva_pkg::in_coord_t apex_x_i,
  input  msva_pkg::in_coord_t apex_y_i,
  input  msva_pkg::in_coord_t apex_z_i,
  input  logic               last_triangle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output msva_pkg::six_t     six_volume_o,
  output msva_pkg::vol_t     mesh_volume_o,
  output logic               saturated_o
);
  import msva_pkg::*;

  coord_t x1_q, y1_q, z1_q, x2_q, y2_q, z2_q, x3_q, y3_q, z3_q;
  logic   last_q;

  minor_t mul_a;
  coord_t mul_b;
  prod_t  prod_d, prod_q;
  minor_t hold_q, minor_q;
  det_t   det_q;

  six_t   acc_q, det_ext, sum, sat_sum;
  logic   ovf_q, ovf;

  six_t   res_six_q;
  logic   res_sat_q, neg_q;
  logic [ACC_W-1:0]  div_num_q;
  logic [WIDE_W-1:0] div_acc_q;
  logic [HALF_W-1:0] pp_a, pp_b;
  logic [ACC_W-1:0]  pp;
  logic [WIDE_W-1:0] pp_ext;
  logic [VOL_W-1:0]  quo;

  logic   out_valid_q;
  six_t   out_six_q;
  vol_t   out_vol_q;
  logic   out_sat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x1_q   <= sext_coord(first_x_i);
      y1_q   <= sext_coord(first_y_i);
      z1_q   <= sext_coord(first_z_i);
      x2_q   <= sext_coord(second_x_i);
      y2_q   <= sext_coord(second_y_i);
      z2_q   <= sext_coord(second_z_i);
      x3_q   <= sext_coord(apex_x_i);
      y3_q   <= sext_coord(apex_y_i);
      z3_q   <= sext_coord(apex_z_i);
      last_q <= last_triangle_i;
    end
  end

  always_comb begin
    mul_a = MIN_W'(y2_q);
    mul_b = z3_q;
    unique case (cmd_i.mul_sel)
      MS_Y2Z3: begin mul_a = MIN_W'(y2_q); mul_b = z3_q; end
      MS_Y3Z2: begin mul_a = MIN_W'(y3_q); mul_b = z2_q; end
      MS_Y3Z1: begin mul_a = MIN_W'(y3_q); mul_b = z1_q; end
      MS_Y1Z3: begin mul_a = MIN_W'(y1_q); mul_b = z3_q; end
      MS_Y1Z2: begin mul_a = MIN_W'(y1_q); mul_b = z2_q; end
      MS_Y2Z1: begin mul_a = MIN_W'(y2_q); mul_b = z1_q; end
      MS_X1M:  begin mul_a = minor_q;      mul_b = x1_q; end
      MS_X2M:  begin mul_a = minor_q;      mul_b = x2_q; end
      MS_X3M:  begin mul_a = minor_q;      mul_b = x3_q; end
      default: begin mul_a = minor_q;      mul_b = x1_q; end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.hold_en)  hold_q  <= minor_t'(prod_q[MIN_W-1:0]);
    if (cmd_i.minor_en) minor_q <= hold_q - minor_t'(prod_q[MIN_W-1:0]);
    unique case (cmd_i.det_op)
      DET_LOAD: det_q <= DET_W'(prod_q);
      DET_ADD:  det_q <= det_q + DET_W'(prod_q);
      default:  det_q <= det_q;
    endcase
  end

  // saturating accumulate
  assign det_ext = ACC_W'(det_q);
  assign sum     = acc_q + det_ext;
  assign ovf     = (acc_q[ACC_W-1] == det_ext[ACC_W-1]) && (sum[ACC_W-1] != acc_q[ACC_W-1]);
  assign sat_sum = !ovf ? sum :
                   acc_q[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (last_q) begin
        acc_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        acc_q <= sat_sum;
        ovf_q <= ovf_q | ovf;
      end
    end
  end

  // magnitude times the reciprocal of six, one 32x32 partial product a cycle
  always_comb begin
    pp_a = div_num_q[HALF_W-1:0];
    pp_b = RECIP6[HALF_W-1:0];
    unique case (cmd_i.pp_sel)
      PP_LL: begin
        pp_a = div_num_q[HALF_W-1:0];
        pp_b = RECIP6[HALF_W-1:0];
      end
      PP_LH: begin
        pp_a = div_num_q[HALF_W-1:0];
        pp_b = RECIP6[ACC_W-1:HALF_W];
      end
      PP_HL: begin
        pp_a = div_num_q[ACC_W-1:HALF_W];
        pp_b = RECIP6[HALF_W-1:0];
      end
      PP_HH: begin
        pp_a = div_num_q[ACC_W-1:HALF_W];
        pp_b = RECIP6[ACC_W-1:HALF_W];
      end
    endcase
  end

  assign pp = pp_a * pp_b;

  always_comb begin
    pp_ext = {{ACC_W{1'b0}}, pp};
    unique case (cmd_i.pp_sel)
      PP_LL:        pp_ext = {{ACC_W{1'b0}}, pp};
      PP_LH, PP_HL: pp_ext = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
      PP_HH:        pp_ext = {pp, {ACC_W{1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en && last_q) begin
      res_six_q <= sat_sum;
      res_sat_q <= ovf_q | ovf;
      neg_q     <= sat_sum[ACC_W-1];
      div_num_q <= sat_sum[ACC_W-1] ? (ACC_W)'(-sat_sum) : (ACC_W)'(sat_sum);
      div_acc_q <= '0;
    end else if (cmd_i.div_step) begin
      div_acc_q <= div_acc_q + pp_ext;
    end
  end

  assign quo = div_acc_q[WIDE_W-1:RECIP_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_six_q <= res_six_q;
      out_vol_q <= neg_q ? vol_t'(-quo) : vol_t'(quo);
      out_sat_q <= res_sat_q;
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign six_volume_o  = out_six_q;
  assign mesh_volume_o = out_vol_q;
  assign saturated_o   = out_sat_q;

endmodule

// ----- rtl/core/mesh_signed_volume_accumulator_core.sv -----
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   three vertices, last_triangle_i
// out       output     out_valid_o / out_stall_i six_volume_o, mesh_volume_o, saturated_o
//
// a triangle is handled as capture, 10 steps through one shared multiplier, then accumulate
// a last triangle adds a divide by six (one 32x32 partial product of a
// reciprocal multiply a cycle) and a load of the output register
// a stalled output holds the block until the register frees up
// reset clears the accumulator, the saturation flag and the output valid
// one transaction is in flight at a time; in_stall_o is low only when idle
module mesh_signed_volume_accumulator_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  msva_pkg::in_coord_t first_x_i,
  input  msva_pkg::in_coord_t first_y_i,
  input  msva_pkg::in_coord_t first_z_i,
  input  msva_pkg::in_coord_t second_x_i,
  input  msva_pkg::in_coord_t second_y_i,
  input  msva_pkg::in_coord_t second_z_i,
  input  msva_pkg::in_coord_t apex_x_i,
  input  msva_pkg::in_coord_t apex_y_i,
  input  msva_pkg::in_coord_t apex_z_i,
  input  logic                last_triangle_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output msva_pkg::six_t      six_volume_o,
  output msva_pkg::vol_t      mesh_volume_o,
  output logic                saturated_o
);
  import msva_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  msva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msva_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .first_x_i       (first_x_i),
    .first_y_i       (first_y_i),
    .first_z_i       (first_z_i),
    .second_x_i      (second_x_i),
    .second_y_i      (second_y_i),
    .second_z_i      (second_z_i),
    .apex_x_i        (apex_x_i),
    .apex_y_i        (apex_y_i),
    .apex_z_i        (apex_z_i),
    .last_triangle_i (last_triangle_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .six_volume_o    (six_volume_o),
    .mesh_volume_o   (mesh_volume_o),
    .saturated_o     (saturated_o)
  );

endmodule
